>>> rtl/sobel_pkg.sv
`default_nettype none

package sobel_pkg;

    // Fixed field widths of the stream and the register file.
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int LW_W    = 11;
    localparam int CFG_DW  = 12;
    localparam int CFG_IW  = 2;
    localparam int LINE_DW = 2 * PIX_W;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IW-1:0] CFG_LINE_WIDTH     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Register reset values.
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST     = 11'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST   = 12'd480;
    localparam logic [PIX_W-1:0] EDGE_THRESHOLD_RST = 8'd100;

    // Smallest width and height the counters work with.
    localparam int MIN_DIM = 3;

    // Largest edge magnitude on the output.
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'hff;

    // The eight pixels of the 3x3 window that the kernels weigh
    // (top, middle and bottom rows; columns 0 to 2 left to right).
    typedef struct packed {
        logic [PIX_W-1:0] t0;
        logic [PIX_W-1:0] t1;
        logic [PIX_W-1:0] t2;
        logic [PIX_W-1:0] m0;
        logic [PIX_W-1:0] m2;
        logic [PIX_W-1:0] b0;
        logic [PIX_W-1:0] b1;
        logic [PIX_W-1:0] b2;
    } win_t;

endpackage

`default_nettype wire

>>> rtl/sobel_ram.sv
`default_nettype none

module sobel_ram #(
    parameter int DW    = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // One write port, one read port with registered data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sobel_kernel.sv
`default_nettype none

module sobel_kernel (
    input  wire sobel_pkg::win_t         win,
    input  wire logic [sobel_pkg::PIX_W-1:0] threshold,
    output logic      [sobel_pkg::PIX_W-1:0] edge_value
);
    import sobel_pkg::*;

    logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
    logic [9:0]  gx_abs, gy_abs;
    logic [10:0] mag;
    logic [PIX_W-1:0] mag_sat;

    // Weighted column and row sums; each stays below 1024.
    assign gx_pos = 10'(win.t2) + {1'b0, win.m2, 1'b0} + 10'(win.b2);
    assign gx_neg = 10'(win.t0) + {1'b0, win.m0, 1'b0} + 10'(win.b0);
    assign gy_pos = 10'(win.b0) + {1'b0, win.b1, 1'b0} + 10'(win.b2);
    assign gy_neg = 10'(win.t0) + {1'b0, win.t1, 1'b0} + 10'(win.t2);

    // Absolute differences avoid a signed intermediate.
    assign gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
    assign gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
    assign mag    = 11'(gx_abs) + 11'(gy_abs);

    // Saturate at full scale, then suppress weak edges.
    assign mag_sat    = (mag > 11'(EDGE_MAX)) ? EDGE_MAX : mag[PIX_W-1:0];
    assign edge_value = (mag_sat < threshold) ? '0 : mag_sat;

endmodule

`default_nettype wire

>>> rtl/sobel_edge_magnitude_top.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tdata: pixel; tuser: frame_start
// m_        out        m_tvalid/m_tready    tdata: edge_value, center_x, center_y;
//                                           tlast: frame_last
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel is taken per cycle while s_tready is high; the line store has one read and one write per cycle.
// A pixel and its line-store read go into the input register, then the kernel
// result goes into the output register.
// Reset is synchronous; the line store is not cleared and holds no valid bits.
// With m_tready low the output register holds, one more pixel fills the input
// register, and s_tready then drops. Border pixels give no result.
`default_nettype none

module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Pixel stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sobel_pkg::PIX_W-1:0]      s_tdata,  // [7:0] pixel
    input  wire logic [0:0]                       s_tuser,  // [0] frame_start
    // Edge stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // edge_value, then center_x, then center_y, zero-filled to whole bytes
    output logic [((sobel_pkg::PIX_W + $clog2(MAX_WIDTH) + sobel_pkg::ROW_W + 7) / 8) * 8 - 1:0]
                                                  m_tdata,
    output logic                                  m_tlast,  // frame_last
    // Configuration writes.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sobel_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [sobel_pkg::CFG_DW-1:0]     cfg_data
);
    import sobel_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WW  = (XW + 1 > LW_W) ? XW + 1 : LW_W;
    localparam int ODW = ((PIX_W + XW + ROW_W + 7) / 8) * 8;

    // Configuration registers.
    logic [LW_W-1:0]  line_width_reg;
    logic [ROW_W-1:0] frame_height_reg;
    logic [PIX_W-1:0] edge_threshold_reg;

    // Raster counters and input register.
    logic [XW-1:0]    col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [XW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    // Line-store bypass for a read of the address written in the same cycle.
    logic               byp_reg;
    logic [LINE_DW-1:0] byp_data_reg;

    // Window columns: [0..2] oldest column top..bottom, [3..5] next column.
    logic [PIX_W-1:0] wc_reg [6];

    // Output register.
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_edge_reg;
    logic [XW-1:0]    out_x_reg;
    logic [ROW_W-1:0] out_y_reg;
    logic             out_last_reg;

    logic               s_acc, s1_fire;
    logic [WW-1:0]      w_use, lw_ext, col_plus1, s1_col_ext;
    logic [ROW_W-1:0]   h_use;
    logic [ROW_W:0]     row_plus1;
    logic [LINE_DW-1:0] ram_rdata, line_q;
    logic [PIX_W-1:0]   top, mid, edge_value;
    logic               res_valid, res_last;
    win_t               win;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg     <= LINE_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:     line_width_reg     <= cfg_data[LW_W-1:0];
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[ROW_W-1:0];
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Width and height in use, clamped to the supported range.
    assign lw_ext = WW'(line_width_reg);
    always_comb begin
        if (lw_ext < WW'(MIN_DIM)) begin
            w_use = WW'(MIN_DIM);
        end else if (lw_ext > WW'(MAX_WIDTH)) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = lw_ext;
        end
    end
    assign h_use = (frame_height_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : frame_height_reg;

    // Handshake: the input register moves on when the output register is free.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_acc    = s_tvalid && s_tready;

    // Raster position of the pixel being accepted and the one after it.
    assign col_cur   = s_tuser[0] ? '0 : col_reg;
    assign row_cur   = s_tuser[0] ? '0 : row_reg;
    assign col_plus1 = WW'(col_cur) + WW'(1);
    assign row_plus1 = {1'b0, row_cur} + 1'b1;

    always_comb begin
        if (col_plus1 >= w_use) begin
            col_next = '0;
            row_next = (row_plus1 >= {1'b0, h_use}) ? '0 : row_plus1[ROW_W-1:0];
        end else begin
            col_next = col_plus1[XW-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end else begin
            if (s_acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
                byp_reg <= s1_fire && (col_cur == s1_col_reg);
            end
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_px_reg    <= s_tdata;
            s1_col_reg   <= col_cur;
            s1_row_reg   <= row_cur;
            byp_data_reg <= {mid, s1_px_reg};
        end
    end

    // Line store: upper byte two rows above, lower byte one row above.
    sobel_ram #(
        .DW    (LINE_DW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data ({mid, s1_px_reg}),
        .rd_en   (s_acc),
        .rd_addr (col_cur),
        .rd_data (ram_rdata)
    );

    assign line_q = byp_reg ? byp_data_reg : ram_rdata;
    assign top    = line_q[LINE_DW-1:PIX_W];
    assign mid    = line_q[PIX_W-1:0];

    // Window shifts by one column per pixel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                wc_reg[i] <= '0;
            end
        end else if (s1_fire) begin
            wc_reg[0] <= wc_reg[3];
            wc_reg[1] <= wc_reg[4];
            wc_reg[2] <= wc_reg[5];
            wc_reg[3] <= top;
            wc_reg[4] <= mid;
            wc_reg[5] <= s1_px_reg;
        end
    end

    always_comb begin
        win.t0 = wc_reg[0];
        win.m0 = wc_reg[1];
        win.b0 = wc_reg[2];
        win.t1 = wc_reg[3];
        win.b1 = wc_reg[5];
        win.t2 = top;
        win.m2 = mid;
        win.b2 = s1_px_reg;
    end

    sobel_kernel u_kernel (
        .win        (win),
        .threshold  (edge_threshold_reg),
        .edge_value (edge_value)
    );

    // Only interior centres give a result.
    assign s1_col_ext = WW'(s1_col_reg);
    assign res_valid  = (s1_col_reg >= XW'(2)) && (s1_col_ext < w_use) &&
                        (s1_row_reg >= ROW_W'(2)) && (s1_row_reg < h_use);
    assign res_last   = (s1_col_ext == w_use - WW'(1)) && (s1_row_reg == h_use - ROW_W'(1));

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && res_valid) begin
            out_edge_reg <= edge_value;
            out_x_reg    <= s1_col_reg - XW'(1);
            out_y_reg    <= s1_row_reg - ROW_W'(1);
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ODW'({out_y_reg, out_x_reg, out_edge_reg});
    assign m_tlast  = out_last_reg;

    // A delivered centre never lies on the top or left border.
    a_center_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_x_reg != '0) && (out_y_reg != '0))
        else $error("result centre on the border");

    // The bypass only fires when a frame restarts on the first column.
    a_bypass_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_reg && s1_valid_reg |-> s1_col_reg == '0)
        else $error("line-store bypass away from column zero");

    // A frame start puts the pixel at the origin.
    a_frame_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> (s1_col_reg == '0) && (s1_row_reg == '0))
        else $error("frame start did not reset the raster position");

endmodule

`default_nettype wire
